// File: design/prc_pkg.sv
// ---------------------------------------------------------------------------
// Pacing rate controller package
// Shared constants, register indexes and controller/datapath types.
// ---------------------------------------------------------------------------
package prc_pkg;

   localparam int USEC_PER_SEC   = 1000000;
   localparam int GAIN_FRAC_BITS = 16;
   localparam int RATE_BITS      = 32;
   localparam int GAIN_BITS      = 16;
   localparam int GAP_BITS       = 24;
   localparam int REF_BITS       = 16;
   localparam int GAP_OUT_BITS   = 32;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [2:0] {
      CSR_CONTROL_MODE    = 3'd0,
      CSR_ADD_STEP        = 3'd1,
      CSR_DECREASE_FACTOR = 3'd2,
      CSR_QUEUE_GAIN      = 3'd3,
      CSR_DAMPING_GAIN    = 3'd4,
      CSR_INITIAL_GAP_US  = 3'd5,
      CSR_MIN_RATE        = 3'd6,
      CSR_MAX_RATE        = 3'd7
   } csr_index_type;

   localparam logic [1:0] MODE_ADDITIVE     = 2'd0;
   localparam logic [1:0] MODE_AIMD         = 2'd1;
   localparam logic [1:0] MODE_PROPORTIONAL = 2'd2;
   localparam logic [1:0] MODE_DAMPED       = 2'd3;

   localparam logic CMD_RESTART  = 1'b0;
   localparam logic CMD_FEEDBACK = 1'b1;

   localparam logic [1:0]           RESET_CONTROL_MODE    = MODE_ADDITIVE;
   localparam logic [RATE_BITS-1:0] RESET_ADD_STEP        = 32'd65536;
   localparam logic [GAIN_BITS-1:0] RESET_DECREASE_FACTOR = 16'd32768;
   localparam logic [GAIN_BITS-1:0] RESET_QUEUE_GAIN      = 16'd6554;
   localparam logic [GAIN_BITS-1:0] RESET_DAMPING_GAIN    = 16'd32768;
   localparam logic [GAP_BITS-1:0]  RESET_INITIAL_GAP_US  = 24'd10000;
   localparam logic [RATE_BITS-1:0] RESET_MIN_RATE        = 32'd65536;
   localparam logic [RATE_BITS-1:0] RESET_MAX_RATE        = 32'hFFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_GAP_START,
      ST_GAP_WAIT,
      ST_RSAT,
      ST_RATE_START,
      ST_RATE_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul_en;
      logic sum_en;
      logic rsat_en;
      logic div_start;
      logic div_sel_rate;
      logic out_load;
   } prc_cmd_type;

   typedef struct packed {
      logic div_done;
   } prc_status_type;

endpackage

// File: design/prc_if.sv
// ---------------------------------------------------------------------------
// Pacing rate controller channels
// Request, response and register-write channels with valid/ready.
// ---------------------------------------------------------------------------
interface prc_req_if #(
   parameter int QUEUE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [QUEUE_BITS-1:0]         queue_level;
   logic [QUEUE_BITS-1:0]         queue_target;
   logic [prc_pkg::REF_BITS-1:0]  reference_rate;

   modport source (output valid, command, queue_level, queue_target, reference_rate,
                   input ready);
   modport sink   (input valid, command, queue_level, queue_target, reference_rate,
                   output ready);
endinterface

interface prc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [prc_pkg::RATE_BITS-1:0]     rate_out;
   logic [prc_pkg::GAP_OUT_BITS-1:0]  gap_us;
   logic                              clamped;

   modport source (output valid, rate_out, gap_us, clamped, input ready);
   modport sink   (input valid, rate_out, gap_us, clamped, output ready);
endinterface

interface prc_csr_if;
   logic                               valid;
   logic                               ready;
   prc_pkg::csr_index_type             index;
   logic [prc_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/prc_divider.sv
// ---------------------------------------------------------------------------
// Pacing rate controller divider
// Restoring divider, one quotient bit per cycle: 1e6 * 2^F over a divisor,
// saturating to all ones on overflow or a zero divisor.
// ---------------------------------------------------------------------------
module prc_divider #(
   parameter int RATE_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [prc_pkg::RATE_BITS-1:0]     divisor,
   output logic                              done,
   output logic [prc_pkg::GAP_OUT_BITS-1:0]  quotient
);
   localparam int NUM_W = 20 + RATE_FRAC_BITS;
   localparam int DW    = (NUM_W > 33) ? NUM_W : 33;
   localparam int CW    = $clog2(DW + 1);
   localparam logic [DW-1:0] NUMERATOR = DW'(prc_pkg::USEC_PER_SEC) << RATE_FRAC_BITS;
   localparam int RW    = prc_pkg::RATE_BITS;

   logic          busy_ff, busy_in;
   logic [CW-1:0] count_ff, count_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [RW-1:0] divisor_ff, divisor_in;
   logic          zero_ff, zero_in;
   logic [RW:0]   shifted;
   logic          fits;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      zero_in    = zero_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CW'(DW);
         rem_in     = '0;
         quo_in     = NUMERATOR;
         divisor_in = divisor;
         zero_in    = (divisor == '0);
      end else if (busy_ff) begin
         rem_in   = fits ? RW'(shifted - {1'b0, divisor_ff}) : RW'(shifted);
         quo_in   = {quo_ff[DW-2:0], fits};
         count_in = count_ff - CW'(1);
         busy_in  = (count_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      zero_ff    <= zero_in;
   end

   assign done     = busy_ff && (count_ff == CW'(1));
   assign quotient = (zero_ff || (|quo_ff[DW-1:32])) ? '1 : quo_ff[31:0];

endmodule

// File: design/prc_datapath.sv
// ---------------------------------------------------------------------------
// Pacing rate controller datapath
// Register file, rate update arithmetic, saturation, divider and result.
// ---------------------------------------------------------------------------
module prc_datapath #(
   parameter int RATE_FRAC_BITS = 16,
   parameter int QUEUE_BITS     = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  prc_pkg::prc_cmd_type               cmd,
   output prc_pkg::prc_status_type            status,
   input  logic                               csr_write,
   input  prc_pkg::csr_index_type             csr_index,
   input  logic [prc_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic [QUEUE_BITS-1:0]              req_queue_level,
   input  logic [QUEUE_BITS-1:0]              req_queue_target,
   input  logic [prc_pkg::REF_BITS-1:0]       req_reference_rate,
   output logic [prc_pkg::RATE_BITS-1:0]      rsp_rate_out,
   output logic [prc_pkg::GAP_OUT_BITS-1:0]   rsp_gap_us,
   output logic                               rsp_clamped
);
   localparam int RW    = prc_pkg::RATE_BITS;
   localparam int GW    = prc_pkg::GAIN_BITS;
   localparam int GF    = prc_pkg::GAIN_FRAC_BITS;
   localparam int ESH_L = (RATE_FRAC_BITS >= GF) ? RATE_FRAC_BITS - GF : 0;
   localparam int ESH_R = (RATE_FRAC_BITS < GF) ? GF - RATE_FRAC_BITS : 0;
   localparam int EP_W  = GW + QUEUE_BITS;
   localparam int ET_W  = EP_W + ESH_L;
   localparam int GM_W  = prc_pkg::REF_BITS + RATE_FRAC_BITS;
   localparam int DM_W  = (GM_W > RW) ? GM_W : RW;
   localparam int SP_W  = GW + DM_W;
   localparam int MX_A  = (ET_W > DM_W) ? ET_W : DM_W;
   localparam int MAG_W = (MX_A > RW + 1) ? MX_A : RW + 1;
   localparam int SUM_W = MAG_W + 3;
   localparam longint RESET_RATE_RAW =
      longint'(prc_pkg::USEC_PER_SEC) * (longint'(1) << RATE_FRAC_BITS)
      / longint'(prc_pkg::RESET_INITIAL_GAP_US);
   localparam logic [RW-1:0] RESET_RATE =
      (RESET_RATE_RAW < longint'(prc_pkg::RESET_MIN_RATE)) ? prc_pkg::RESET_MIN_RATE
                                                          : RW'(RESET_RATE_RAW);

   logic [1:0]            mode_ff;
   logic [RW-1:0]         add_step_ff;
   logic [GW-1:0]         decrease_ff;
   logic [GW-1:0]         queue_gain_ff;
   logic [GW-1:0]         damping_ff;
   logic [prc_pkg::GAP_BITS-1:0] init_gap_ff;
   logic [RW-1:0]         min_rate_ff;
   logic [RW-1:0]         max_rate_ff;

   logic [QUEUE_BITS-1:0] level_ff, target_ff;
   logic [prc_pkg::REF_BITS-1:0] gamma_ff;
   logic [RW-1:0]         rate_ff, rate_in;
   logic                  clamped_ff, clamped_in;
   logic [EP_W-1:0]       eprod_ff, eprod_in;
   logic [SP_W-1:0]       sprod_ff, sprod_in;
   logic                  below_ff, above_ff, dneg_ff;
   logic                  below_in, above_in, dneg_in;

   logic [QUEUE_BITS-1:0] emag;
   logic [DM_W-1:0]       gamma_x, rate_x, dmag, smag;
   logic [GW-1:0]         sgain;
   logic [SUM_W-1:0]      r_s, step_s, et_s, st_s, v_sum, sat_in, min_s, max_s;
   logic [RW-1:0]         sat_out;
   logic                  sat_hit;
   logic [RW-1:0]         div_divisor;
   logic [RW-1:0]         gap_divisor;
   logic [prc_pkg::GAP_OUT_BITS-1:0] div_quotient;
   logic                  div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= prc_pkg::RESET_CONTROL_MODE;
         add_step_ff   <= prc_pkg::RESET_ADD_STEP;
         decrease_ff   <= prc_pkg::RESET_DECREASE_FACTOR;
         queue_gain_ff <= prc_pkg::RESET_QUEUE_GAIN;
         damping_ff    <= prc_pkg::RESET_DAMPING_GAIN;
         init_gap_ff   <= prc_pkg::RESET_INITIAL_GAP_US;
         min_rate_ff   <= prc_pkg::RESET_MIN_RATE;
         max_rate_ff   <= prc_pkg::RESET_MAX_RATE;
      end else if (csr_write) begin
         case (csr_index)
            prc_pkg::CSR_CONTROL_MODE:    mode_ff       <= csr_data[1:0];
            prc_pkg::CSR_ADD_STEP:        add_step_ff   <= csr_data[RW-1:0];
            prc_pkg::CSR_DECREASE_FACTOR: decrease_ff   <= csr_data[GW-1:0];
            prc_pkg::CSR_QUEUE_GAIN:      queue_gain_ff <= csr_data[GW-1:0];
            prc_pkg::CSR_DAMPING_GAIN:    damping_ff    <= csr_data[GW-1:0];
            prc_pkg::CSR_INITIAL_GAP_US:  init_gap_ff   <= csr_data[prc_pkg::GAP_BITS-1:0];
            prc_pkg::CSR_MIN_RATE:        min_rate_ff   <= csr_data[RW-1:0];
            prc_pkg::CSR_MAX_RATE:        max_rate_ff   <= csr_data[RW-1:0];
            default: begin
            end
         endcase
      end
   end

   // product stage
   always_comb begin
      below_in = level_ff < target_ff;
      above_in = level_ff > target_ff;
      emag     = below_in ? target_ff - level_ff : level_ff - target_ff;
      gamma_x  = DM_W'(gamma_ff) << RATE_FRAC_BITS;
      rate_x   = DM_W'(rate_ff);
      dneg_in  = rate_x < gamma_x;
      dmag     = dneg_in ? gamma_x - rate_x : rate_x - gamma_x;
      sgain    = (mode_ff == prc_pkg::MODE_AIMD) ? decrease_ff : damping_ff;
      smag     = (mode_ff == prc_pkg::MODE_AIMD) ? rate_x : dmag;
      eprod_in = EP_W'(queue_gain_ff) * EP_W'(emag);
      sprod_in = SP_W'(sgain) * SP_W'(smag);
   end

   // sum stage
   always_comb begin
      r_s    = SUM_W'(rate_ff);
      step_s = SUM_W'(add_step_ff);
      et_s   = (SUM_W'(eprod_ff) << ESH_L) >> ESH_R;
      st_s   = SUM_W'(sprod_ff[SP_W-1:GF]);
      case (mode_ff)
         prc_pkg::MODE_ADDITIVE:
            v_sum = below_ff ? r_s + step_s : (above_ff ? r_s - step_s : r_s);
         prc_pkg::MODE_AIMD:
            v_sum = below_ff ? r_s + step_s : (above_ff ? st_s : r_s);
         prc_pkg::MODE_PROPORTIONAL:
            v_sum = above_ff ? r_s - et_s : r_s + et_s;
         prc_pkg::MODE_DAMPED:
            v_sum = (above_ff ? r_s - et_s : r_s + et_s) + (dneg_ff ? st_s : -st_s);
         default:
            v_sum = r_s;
      endcase
   end

   // saturation, shared by restart and feedback
   always_comb begin
      sat_in  = cmd.rsat_en ? SUM_W'(div_quotient) : v_sum;
      min_s   = SUM_W'(min_rate_ff);
      max_s   = SUM_W'(max_rate_ff);
      sat_hit = 1'b1;
      if ($signed(sat_in) < $signed(min_s)) begin
         sat_out = min_rate_ff;
      end else if ($signed(sat_in) > $signed(max_s)) begin
         sat_out = max_rate_ff;
      end else begin
         sat_out = sat_in[RW-1:0];
         sat_hit = 1'b0;
      end
      rate_in    = (cmd.sum_en || cmd.rsat_en) ? sat_out : rate_ff;
      clamped_in = (cmd.sum_en || cmd.rsat_en) ? sat_hit : clamped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= RESET_RATE;
         clamped_ff <= 1'b0;
      end else begin
         rate_ff    <= rate_in;
         clamped_ff <= clamped_in;
      end
      if (cmd.capture) begin
         level_ff  <= req_queue_level;
         target_ff <= req_queue_target;
         gamma_ff  <= req_reference_rate;
      end
      if (cmd.mul_en) begin
         eprod_ff <= eprod_in;
         sprod_ff <= sprod_in;
         below_ff <= below_in;
         above_ff <= above_in;
         dneg_ff  <= dneg_in;
      end
      if (cmd.out_load) begin
         rsp_rate_out <= rate_ff;
         rsp_gap_us   <= div_quotient;
         rsp_clamped  <= clamped_ff;
      end
   end

   assign gap_divisor = (init_gap_ff == '0) ? RW'(1) : RW'(init_gap_ff);
   assign div_divisor = cmd.div_sel_rate ? rate_ff : gap_divisor;

   prc_divider #(
      .RATE_FRAC_BITS (RATE_FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign status.div_done = div_done;

endmodule

// File: design/prc_ctrl.sv
// ---------------------------------------------------------------------------
// Pacing rate controller sequencer
// Steps one request through product/sum or gap divide, rate divide and load.
// ---------------------------------------------------------------------------
module prc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output prc_pkg::prc_cmd_type     cmd,
   input  prc_pkg::prc_status_type  status
);
   prc_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               slot_free;

   assign accept    = req_valid && (state_ff == prc_pkg::ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prc_pkg::ST_IDLE:
            if (accept) begin
               state_in = (req_command == prc_pkg::CMD_FEEDBACK) ? prc_pkg::ST_MUL
                                                                 : prc_pkg::ST_GAP_START;
            end
         prc_pkg::ST_MUL:        state_in = prc_pkg::ST_SUM;
         prc_pkg::ST_SUM:        state_in = prc_pkg::ST_RATE_START;
         prc_pkg::ST_GAP_START:  state_in = prc_pkg::ST_GAP_WAIT;
         prc_pkg::ST_GAP_WAIT:
            if (status.div_done) begin
               state_in = prc_pkg::ST_RSAT;
            end
         prc_pkg::ST_RSAT:       state_in = prc_pkg::ST_RATE_START;
         prc_pkg::ST_RATE_START: state_in = prc_pkg::ST_RATE_WAIT;
         prc_pkg::ST_RATE_WAIT:
            if (status.div_done) begin
               state_in = prc_pkg::ST_OUT;
            end
         prc_pkg::ST_OUT:
            if (slot_free) begin
               state_in = prc_pkg::ST_IDLE;
            end
         default:                state_in = prc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd              = '0;
      cmd.capture      = accept;
      cmd.mul_en       = (state_ff == prc_pkg::ST_MUL);
      cmd.sum_en       = (state_ff == prc_pkg::ST_SUM);
      cmd.rsat_en      = (state_ff == prc_pkg::ST_RSAT);
      cmd.div_start    = (state_ff == prc_pkg::ST_GAP_START) ||
                         (state_ff == prc_pkg::ST_RATE_START);
      cmd.div_sel_rate = (state_ff == prc_pkg::ST_RATE_START);
      cmd.out_load     = (state_ff == prc_pkg::ST_OUT) && slot_free;
      rsp_valid_in     = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == prc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/pacing_rate_controller.sv
// ---------------------------------------------------------------------------
// Pacing rate controller
// Sender rate control: additive, AIMD, proportional and damped update modes.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one request: command 0 restarts the rate from
//   initial_gap_us, command 1 applies queue feedback. rsp_bus returns
//   one response per request: the new Q16.16 rate, the packet gap in
//   microseconds and a flag set when the rate hit min_rate or max_rate.
//   csr_bus writes the eight registers by index and is always ready; the user
//   must write it only while no request is in flight; it is not enforced.
// Timing (D = 20 + RATE_FRAC_BITS quotient bits, 36 at the default):
//   feedback runs one D-bit divide and restart two, in the restoring
//   divider at one quotient bit per cycle; one request is worked at a time,
//   and the next request is taken in the cycle after the response is loaded.
//   The response register lets the next request enter while a response
//   waits; a stalled receiver holds the next response in the sequencer.
// Reset:
//   registers return to their defaults and the rate to 1e6 / 10000 us,
//   raised to the minimum rate; no response is pending.
// ---------------------------------------------------------------------------
module pacing_rate_controller #(
   parameter int RATE_FRAC_BITS = 16,
   parameter int QUEUE_BITS     = 24
) (
   input  logic       clock,
   input  logic       reset,
   prc_req_if.sink    req_bus,
   prc_rsp_if.source  rsp_bus,
   prc_csr_if.sink    csr_bus
);
   prc_pkg::prc_cmd_type    cmd;
   prc_pkg::prc_status_type status;

   assign csr_bus.ready = 1'b1;

   prc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_command (req_bus.command),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .cmd         (cmd),
      .status      (status)
   );

   prc_datapath #(
      .RATE_FRAC_BITS (RATE_FRAC_BITS),
      .QUEUE_BITS     (QUEUE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data),
      .req_queue_level    (req_bus.queue_level),
      .req_queue_target   (req_bus.queue_target),
      .req_reference_rate (req_bus.reference_rate),
      .rsp_rate_out       (rsp_bus.rate_out),
      .rsp_gap_us         (rsp_bus.gap_us),
      .rsp_clamped        (rsp_bus.clamped)
   );

endmodule

// File: design/prc_checker.sv
// ---------------------------------------------------------------------------
// Pacing rate controller port checker
// Response handshake and result sanity seen at the top-level ports.
// ---------------------------------------------------------------------------
module prc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [prc_pkg::RATE_BITS-1:0]     rsp_rate_out,
   input logic [prc_pkg::GAP_OUT_BITS-1:0]  rsp_gap_us
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rate_out) && $stable(rsp_gap_us))
      else $error("response dropped or changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after request");

   a_zero_rate_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_rate_out == '0) |-> (rsp_gap_us == '1))
      else $error("zero rate without saturated gap");
endmodule

bind pacing_rate_controller prc_checker u_prc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_rate_out (rsp_bus.rate_out),
   .rsp_gap_us   (rsp_bus.gap_us)
);
